### rtl/tsfd_pkg.sv
package tsfd_pkg;

  localparam int unsigned TickW = 16;
  localparam int unsigned FracW = 15;
  localparam int unsigned CfgIdxW = 8;

  localparam logic [TickW-1:0] PeriodReset = 16'd1000;
  localparam logic [FracW-1:0] DenReset = 15'd1;
  localparam logic [TickW-1:0] ElapGuard = 16'hffff;

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] RegPeriodInt = 8'd0;
  localparam logic [CfgIdxW-1:0] RegFracEnable = 8'd1;
  localparam logic [CfgIdxW-1:0] RegFracNum = 8'd2;
  localparam logic [CfgIdxW-1:0] RegFracDen = 8'd3;

  typedef struct packed {
    logic [TickW-1:0] period_int;
    logic             frac_enable;
    logic [FracW-1:0] frac_num;
    logic [FracW-1:0] frac_den;
  } cfg_t;

  // timekeeping state carried between passes
  typedef struct packed {
    logic [TickW-1:0] cnt;
    logic [TickW-1:0] bnd;
    logic [TickW-1:0] err;
  } tk_state_t;

endpackage

### rtl/tsfd_step.sv
module tsfd_step (
  input  tsfd_pkg::cfg_t              cfg,
  input  logic [tsfd_pkg::TickW-1:0]  now,
  input  logic                        first,
  input  tsfd_pkg::tk_state_t         cur,
  output tsfd_pkg::tk_state_t         nxt,
  output logic                        more
);

  logic [tsfd_pkg::TickW-1:0] per;
  logic [tsfd_pkg::TickW:0]   step;
  logic [tsfd_pkg::TickW-1:0] elap;
  logic [tsfd_pkg::TickW-1:0] inc;
  logic [tsfd_pkg::TickW-1:0] err_sum;
  logic [tsfd_pkg::TickW-1:0] den16;
  logic                       pull_back;
  logic [tsfd_pkg::TickW-1:0] bnd_adv;

  always_comb begin
    // zero period counts as one tick
    per   = (cfg.period_int == '0) ? {{(tsfd_pkg::TickW-1){1'b0}}, 1'b1} : cfg.period_int;
    step  = {1'b0, per} + {{tsfd_pkg::TickW{1'b0}}, 1'b1};
    den16 = {1'b0, cfg.frac_den};
    inc   = den16 - {1'b0, cfg.frac_num};

    // continue test on the current boundary
    elap = now - cur.bnd;
    if (cfg.frac_enable) begin
      more = ({1'b0, elap} >= step);
    end else begin
      more = (elap >= per) && (first || (elap != tsfd_pkg::ElapGuard));
    end

    // one catch-up pass
    nxt.cnt = cur.cnt + {{(tsfd_pkg::TickW-1){1'b0}}, 1'b1};
    if (cfg.frac_enable) begin
      err_sum   = cur.err + inc;
      pull_back = (err_sum >= den16);
      bnd_adv   = cur.bnd + step[tsfd_pkg::TickW-1:0];
      nxt.err   = pull_back ? (err_sum - den16) : err_sum;
      nxt.bnd   = pull_back ? (bnd_adv - {{(tsfd_pkg::TickW-1){1'b0}}, 1'b1}) : bnd_adv;
    end else begin
      err_sum   = cur.err;
      pull_back = 1'b0;
      bnd_adv   = cur.bnd + per;
      nxt.err   = cur.err;
      nxt.bnd   = bnd_adv;
    end
  end

endmodule

### rtl/tick_to_seconds_fractional_divider.sv
// tick snapshot to seconds converter with integer or fractional period
//
// input channel: in_valid / in_stall carry one tick snapshot (in_tick_now);
// the item is taken when in_valid is high and in_stall low. in_stall is high
// while an item is being worked on, so one item is in the block at a time.
// result channel: out_valid / out_stall carry tick value, seconds count and
// the second_advanced flag from an output register; a stalled result holds.
// config channel: cfg_valid / cfg_ready with cfg_index (0 period_int,
// 1 frac_enable, 2 frac_num, 3 frac_den) and cfg_data; other indexes ignored.
// catch-up: the single step unit makes one catch-up pass per elapsed second,
// each pass a step state followed by a check state, and after the last check
// the result is loaded into the output register; the next item is taken
// only once the block is back in idle, which it enters as the result is loaded
// a stalled result holds the finished item until the output register frees
// reset: seconds, boundary and error clear to zero, period_int 1000,
// frac_enable 0, frac_num 0, frac_den 1, no result pending
module tick_to_seconds_fractional_divider (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tsfd_pkg::TickW-1:0]    in_tick_now,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tsfd_pkg::TickW-1:0]    out_tick_value,
  output logic [tsfd_pkg::TickW-1:0]    out_seconds,
  output logic                          out_second_advanced,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tsfd_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [tsfd_pkg::TickW-1:0]    cfg_data
);

  typedef enum logic [1:0] {ST_IDLE, ST_CHECK, ST_STEP, ST_DONE} state_t;

  state_t                     state_r, state_nxt;
  tsfd_pkg::cfg_t             cfg_r, cfg_nxt;
  tsfd_pkg::tk_state_t        tk_r, tk_nxt;
  tsfd_pkg::tk_state_t        step_res;
  logic [tsfd_pkg::TickW-1:0] now_r, now_nxt;
  logic                       first_r, first_nxt;
  logic                       adv_r, adv_nxt;
  logic                       more;
  logic                       out_free;
  logic                       ov_r, ov_nxt;
  logic [tsfd_pkg::TickW-1:0] otick_r, otick_nxt;
  logic [tsfd_pkg::TickW-1:0] osec_r, osec_nxt;
  logic                       oadv_r, oadv_nxt;

  // one catch-up pass and the continue test
  tsfd_step u_step (
    .cfg   (cfg_r),
    .now   (now_r),
    .first (first_r),
    .cur   (tk_r),
    .nxt   (step_res),
    .more  (more)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  // output register free now or emptied at this edge
  assign out_free  = !ov_r || !out_stall;

  assign out_valid           = ov_r;
  assign out_tick_value      = otick_r;
  assign out_seconds         = osec_r;
  assign out_second_advanced = oadv_r;

  always_comb begin
    state_nxt = state_r;
    cfg_nxt   = cfg_r;
    tk_nxt    = tk_r;
    now_nxt   = now_r;
    first_nxt = first_r;
    adv_nxt   = adv_r;
    ov_nxt    = ov_r && out_stall;
    otick_nxt = otick_r;
    osec_nxt  = osec_r;
    oadv_nxt  = oadv_r;

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tsfd_pkg::RegPeriodInt:  cfg_nxt.period_int  = cfg_data;
        tsfd_pkg::RegFracEnable: cfg_nxt.frac_enable = cfg_data[0];
        tsfd_pkg::RegFracNum:    cfg_nxt.frac_num    = cfg_data[tsfd_pkg::FracW-1:0];
        tsfd_pkg::RegFracDen:    cfg_nxt.frac_den    = cfg_data[tsfd_pkg::FracW-1:0];
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          now_nxt   = in_tick_now;
          first_nxt = 1'b1;
          adv_nxt   = 1'b0;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_nxt = more ? ST_STEP : ST_DONE;
      end
      ST_STEP: begin
        tk_nxt    = step_res;
        first_nxt = 1'b0;
        adv_nxt   = 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_DONE: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          otick_nxt = now_r;
          osec_nxt  = tk_r.cnt;
          oadv_nxt  = adv_r;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r            <= ST_IDLE;
      cfg_r.period_int   <= tsfd_pkg::PeriodReset;
      cfg_r.frac_enable  <= 1'b0;
      cfg_r.frac_num     <= '0;
      cfg_r.frac_den     <= tsfd_pkg::DenReset;
      tk_r               <= '0;
      first_r            <= 1'b0;
      adv_r              <= 1'b0;
      ov_r               <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cfg_r   <= cfg_nxt;
      tk_r    <= tk_nxt;
      first_r <= first_nxt;
      adv_r   <= adv_nxt;
      ov_r    <= ov_nxt;
    end
    now_r   <= now_nxt;
    otick_r <= otick_nxt;
    osec_r  <= osec_nxt;
    oadv_r  <= oadv_nxt;
  end

`ifndef SYNTHESIS
  // an accepted item always goes to the continue test first
  a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_CHECK && first_r))
    else $error("accepted item did not enter check");

  // each pass advances the seconds count by exactly one
  a_step_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STEP) |=> (tk_r.cnt == $past(tk_r.cnt) + 16'd1 && adv_r))
    else $error("catch-up pass did not advance seconds by one");

  // a finished item with a free output slot is presented next cycle
  a_done_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_free) |=> (out_valid && state_r == ST_IDLE
      && out_seconds == tk_r.cnt))
    else $error("finished item not loaded into output register");

  // seconds only move while an item is being worked on
  a_cnt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE || state_r == ST_DONE) |=> $stable(tk_r))
    else $error("timekeeping state changed outside a pass");
`endif

endmodule

### sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TickW = tsfd_pkg::TickW;
  localparam int unsigned FracW = tsfd_pkg::FracW;
  localparam int unsigned CfgIdxW = tsfd_pkg::CfgIdxW;

  localparam int unsigned NumPhases = 8;
  localparam int unsigned PhaseItems = 75;
  // long output hold that lets the block back up into its input
  localparam int unsigned HoldCycles = 150;
  // quiet cycles after the last result before a register write or the end
  localparam int unsigned SettleCycles = 8;

  // one result item: tick copy, seconds count, advance flag
  typedef struct packed {
    logic [TickW-1:0] tick_value;
    logic [TickW-1:0] seconds;
    logic             second_advanced;
  } sec_result_t;

  // directed rows: a register write, a tick snapshot, or a snapshot given
  // as an offset from the current second boundary
  typedef enum logic [1:0] {RowCfg, RowTick, RowTickRel} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [CfgIdxW-1:0] idx;
    logic [TickW-1:0]   data;
    logic               has_exp;
    logic [TickW-1:0]   exp_seconds;
    logic               exp_adv;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [TickW-1:0]   in_tick_now = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [TickW-1:0]   out_tick_value;
  logic [TickW-1:0]   out_seconds;
  logic               out_second_advanced;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [TickW-1:0]   cfg_data = '0;

  // predictor copy of the registers and timekeeping state
  tsfd_pkg::cfg_t      cur_cfg = '{period_int: tsfd_pkg::PeriodReset, frac_enable: 1'b0,
                                   frac_num: '0, frac_den: tsfd_pkg::DenReset};
  tsfd_pkg::tk_state_t cur_tk = '0;

  sec_result_t due_results[$];
  dir_row_t    dir_rows[$];

  int unsigned n_items = 0;
  int unsigned n_results = 0;
  int unsigned n_adv = 0;
  int unsigned n_cfg = 0;
  int unsigned n_errors = 0;

  // sender -> receiver requests
  bit hold_req = 1'b0;
  bit no_idle = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tick_to_seconds_fractional_divider u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_tick_now         (in_tick_now),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_tick_value      (out_tick_value),
    .out_seconds         (out_seconds),
    .out_second_advanced (out_second_advanced),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  // seconds update for one tick snapshot; moves the predictor state along
  function automatic sec_result_t advance_seconds(input logic [TickW-1:0] now);
    logic [TickW-1:0]    per;
    logic [TickW-1:0]    elap;
    logic [TickW-1:0]    inc;
    logic [TickW:0]      stride;
    sec_result_t         res;
    tsfd_pkg::tk_state_t tk;
    tk = cur_tk;
    // a zero period counts as one tick so the catch-up always ends
    per = cur_cfg.period_int;
    if (per == '0) per = 16'd1;
    elap = now - tk.bnd;
    res.second_advanced = 1'b0;
    if (!cur_cfg.frac_enable) begin
      if (elap >= per) begin
        res.second_advanced = 1'b1;
        do begin
          tk.cnt = tk.cnt + 16'd1;
          tk.bnd = tk.bnd + per;
          elap = now - tk.bnd;
        end while (elap >= per && elap != tsfd_pkg::ElapGuard);
      end
    end else begin
      // bresenham: long steps of per+1, one tick taken back on error overflow
      stride = {1'b0, per} + 17'd1;
      inc = {1'b0, cur_cfg.frac_den} - {1'b0, cur_cfg.frac_num};
      if ({1'b0, elap} >= stride) begin
        res.second_advanced = 1'b1;
        do begin
          tk.cnt = tk.cnt + 16'd1;
          tk.bnd = tk.bnd + stride[TickW-1:0];
          tk.err = tk.err + inc;
          if (tk.err >= {1'b0, cur_cfg.frac_den}) begin
            tk.err = tk.err - {1'b0, cur_cfg.frac_den};
            tk.bnd = tk.bnd - 16'd1;
          end
          elap = now - tk.bnd;
        end while ({1'b0, elap} >= stride);
      end
    end
    cur_tk = tk;
    res.tick_value = now;
    res.seconds = tk.cnt;
    return res;
  endfunction

  // next snapshot: a few seconds past the boundary at most, so the
  // catch-up stays short; whole-range noise only with long periods
  function automatic logic [TickW-1:0] pick_tick();
    int unsigned per;
    int unsigned elapsed;
    per = (cur_cfg.period_int == '0) ? 32'd1 : 32'(cur_cfg.period_int);
    if (cur_cfg.frac_enable) per = per + 1;
    if (per >= 256 && $urandom_range(0, 9) == 0) return 16'($urandom_range(0, 65535));
    if ($urandom_range(0, 3) == 0)
      // right around a second boundary
      elapsed = $urandom_range(1, 3) * per + $urandom_range(0, 2) - 1;
    else
      elapsed = $urandom_range(0, per * 4 + 7);
    if (elapsed > 65535) elapsed = 65535;
    return cur_tk.bnd + elapsed[TickW-1:0];
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_row(input row_kind_t kind, input logic [CfgIdxW-1:0] idx,
                         input logic [TickW-1:0] data, input logic has_exp,
                         input logic [TickW-1:0] exp_seconds, input logic exp_adv);
    dir_row_t row;
    row = {kind, idx, data, has_exp, exp_seconds, exp_adv};
    dir_rows.push_back(row);
  endtask

  // offer one snapshot and hold it until taken; valid stays high on return
  task automatic send_tick(input logic [TickW-1:0] tick, input logic typed,
                           input sec_result_t typed_res);
    sec_result_t res;
    @(negedge clk);
    in_valid <= 1'b1;
    in_tick_now <= tick;
    do @(posedge clk); while (in_stall);
    res = advance_seconds(tick);
    due_results.push_back(typed ? typed_res : res);
    n_items++;
  endtask

  task automatic pause_sender(input int unsigned n);
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // stop offering and let every due result come out
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [TickW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      tsfd_pkg::RegPeriodInt:  cur_cfg.period_int = data;
      tsfd_pkg::RegFracEnable: cur_cfg.frac_enable = data[0];
      tsfd_pkg::RegFracNum:    cur_cfg.frac_num = data[FracW-1:0];
      tsfd_pkg::RegFracDen:    cur_cfg.frac_den = data[FracW-1:0];
      default: ;
    endcase
    n_cfg++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // result side: random stall runs, calm stretches, one long hold on request
  initial begin : result_sink
    int unsigned run_left;
    int unsigned hold_left;
    logic        run_val;
    run_left = 0;
    hold_left = 0;
    run_val = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && hold_req) begin
        hold_req = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (no_idle) begin
        run_left = 0;
        run_val = 1'b0;
        out_stall <= 1'b0;
      end else begin
        if (run_left == 0) begin
          run_val = !run_val;
          run_left = run_val ? idle_len() + 1 : $urandom_range(1, 12);
        end
        run_left--;
        out_stall <= run_val;
      end
    end
  end

  // compare every accepted result with the oldest due one
  always @(posedge clk) begin : check_results
    sec_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (out_second_advanced) n_adv++;
      if (due_results.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result tick %h seconds %0d adv %b", $time,
                 out_tick_value, out_seconds, out_second_advanced);
      end else begin
        want = due_results.pop_front();
        if (out_tick_value !== want.tick_value) begin
          n_errors++;
          $display("%0t: tick_value mismatch, expected %h got %h", $time,
                   want.tick_value, out_tick_value);
        end
        if (out_seconds !== want.seconds) begin
          n_errors++;
          $display("%0t: seconds mismatch, expected %0d got %0d", $time,
                   want.seconds, out_seconds);
        end
        if (out_second_advanced !== want.second_advanced) begin
          n_errors++;
          $display("%0t: second_advanced mismatch, expected %b got %b", $time,
                   want.second_advanced, out_second_advanced);
        end
      end
    end
  end

  initial begin : stimulus
    dir_row_t         row;
    sec_result_t      want;
    logic [TickW-1:0] c_per;
    logic [TickW-1:0] c_num;
    logic [TickW-1:0] c_den;
    logic             c_fe;

    // directed rows; typed expectations only where obvious
    // fresh after reset: nothing elapsed, then exactly one period
    add_row(RowTick, '0, 16'h0000, 1'b1, 16'd0, 1'b0);
    add_row(RowTick, '0, 16'd999, 1'b1, 16'd0, 1'b0);
    add_row(RowTick, '0, 16'd1000, 1'b1, 16'd1, 1'b1);
    // top of the tick range: many seconds caught up in one update
    add_row(RowTick, '0, 16'hffff, 1'b0, '0, 1'b0);
    // tick source wraps past zero
    add_row(RowTick, '0, 16'h0000, 1'b0, '0, 1'b0);
    // zero period behaves as one tick
    add_row(RowCfg, tsfd_pkg::RegPeriodInt, 16'h0000, 1'b0, '0, 1'b0);
    add_row(RowTickRel, '0, 16'd10, 1'b0, '0, 1'b0);
    // largest period, integer: only a full 0xffff elapsed advances
    add_row(RowCfg, tsfd_pkg::RegPeriodInt, 16'hffff, 1'b0, '0, 1'b0);
    add_row(RowTickRel, '0, 16'hffff, 1'b0, '0, 1'b0);
    // largest period, fractional: step exceeds any 16-bit elapsed
    add_row(RowCfg, tsfd_pkg::RegFracEnable, 16'h0001, 1'b0, '0, 1'b0);
    add_row(RowTickRel, '0, 16'hffff, 1'b0, '0, 1'b0);
    // one and a third ticks per second
    add_row(RowCfg, tsfd_pkg::RegPeriodInt, 16'd1, 1'b0, '0, 1'b0);
    add_row(RowCfg, tsfd_pkg::RegFracNum, 16'd1, 1'b0, '0, 1'b0);
    add_row(RowCfg, tsfd_pkg::RegFracDen, 16'd3, 1'b0, '0, 1'b0);
    add_row(RowTickRel, '0, 16'd20, 1'b0, '0, 1'b0);
    // numerator above denominator: increment wraps
    add_row(RowCfg, tsfd_pkg::RegFracNum, 16'd5, 1'b0, '0, 1'b0);
    add_row(RowTickRel, '0, 16'd40, 1'b0, '0, 1'b0);
    // zero denominator: every step pulled back
    add_row(RowCfg, tsfd_pkg::RegFracDen, 16'd0, 1'b0, '0, 1'b0);
    add_row(RowTickRel, '0, 16'd12, 1'b0, '0, 1'b0);
    // unused indexes are dropped, upper data bits masked off
    add_row(RowCfg, 8'hff, 16'h1234, 1'b0, '0, 1'b0);
    add_row(RowCfg, 8'd4, 16'hffff, 1'b0, '0, 1'b0);
    add_row(RowCfg, tsfd_pkg::RegFracNum, 16'h8003, 1'b0, '0, 1'b0);
    add_row(RowCfg, tsfd_pkg::RegFracDen, 16'hffff, 1'b0, '0, 1'b0);
    add_row(RowCfg, tsfd_pkg::RegFracEnable, 16'hffff, 1'b0, '0, 1'b0);
    add_row(RowCfg, tsfd_pkg::RegPeriodInt, 16'd1000, 1'b0, '0, 1'b0);
    add_row(RowTick, '0, 16'h0000, 1'b0, '0, 1'b0);
    add_row(RowTick, '0, 16'hffff, 1'b0, '0, 1'b0);
    // back to integer, one tick per second: a long catch-up loop
    add_row(RowCfg, tsfd_pkg::RegFracEnable, 16'h0000, 1'b0, '0, 1'b0);
    add_row(RowCfg, tsfd_pkg::RegPeriodInt, 16'd1, 1'b0, '0, 1'b0);
    add_row(RowTickRel, '0, 16'd3000, 1'b0, '0, 1'b0);

    // reset, released on a falling edge
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      want = {row.data, row.exp_seconds, row.exp_adv};
      case (row.kind)
        RowCfg: begin
          // registers change only with nothing in flight
          wait_idle();
          write_reg(row.idx, row.data);
        end
        RowTick:    send_tick(row.data, row.has_exp, want);
        RowTickRel: send_tick(cur_tk.bnd + row.data, 1'b0, want);
        default: ;
      endcase
      pause_sender(idle_len());
    end

    // random phases, each under its own setting
    for (int p = 0; p < NumPhases; p++) begin
      wait_idle();
      c_fe = 1'b1;
      c_per = 16'($urandom_range(1, 2000));
      c_den = 16'($urandom_range(1, 32767));
      c_num = 16'($urandom_range(0, 32'(c_den) - 1));
      case (p)
        0: c_fe = 1'b0;
        2: begin
          c_fe = 1'b0;
          c_per = 16'd1;
        end
        3: c_per = 16'd65534;
        4: begin
          c_fe = 1'b0;
          c_per = 16'd65534;
        end
        5: begin
          c_per = 16'd1;
          c_num = 16'd32766;
          c_den = 16'd32767;
        end
        // numerator at or above denominator
        6: c_num = 16'($urandom_range(32'(c_den), 32767));
        // anything the fields can hold
        7: begin
          c_fe = 1'($urandom_range(0, 1));
          c_per = 16'($urandom_range(0, 65535));
          c_num = 16'($urandom_range(0, 65535));
          c_den = 16'($urandom_range(0, 65535));
        end
        default: ;
      endcase
      // junk in the bit above the 15-bit fields
      if (p != 7) begin
        c_num[15] = 1'($urandom_range(0, 1));
        c_den[15] = 1'($urandom_range(0, 1));
      end
      write_reg(tsfd_pkg::RegPeriodInt, c_per);
      write_reg(tsfd_pkg::RegFracEnable, {15'($urandom_range(0, 32767)), c_fe});
      write_reg(tsfd_pkg::RegFracNum, c_num);
      write_reg(tsfd_pkg::RegFracDen, c_den);

      for (int k = 0; k < PhaseItems; k++) begin
        // back-to-back stretch at the start of every other phase
        no_idle = (p % 2 == 0) && (k < 20);
        // receiver holds off while snapshots keep coming
        if (p == 1 && k == 10) hold_req = 1'b1;
        // sender waits for everything to come back mid-phase
        if (p == 5 && k == 40) wait_idle();
        send_tick(pick_tick(), 1'b0, '0);
        pause_sender(no_idle ? 0 : idle_len());
      end
      no_idle = 1'b0;
    end

    wait_idle();
    $display("%0d tick snapshots, %0d results (%0d advancing seconds) checked", n_items,
             n_results, n_adv);
    $display("%0d register writes, integer and fractional periods incl. extremes", n_cfg);
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // worst honest run stays well within the timeout: 600 snapshots with short
  // catch-ups, long gaps and stalls, one long hold and the long directed loop
  initial begin : watchdog
    #20_000_000;
    $display("timeout with %0d results still due", due_results.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
